// ===== src/bps_pkg.sv =====
// Shared types and constants for the boot pulse sequencer.
`timescale 1ns / 1ps

package bps_pkg;

  // phase codes
  localparam logic [2:0] PH_WAIT_HIGH = 3'd0;
  localparam logic [2:0] PH_WAIT_LOW  = 3'd1;
  localparam logic [2:0] PH_GAP       = 3'd2;
  localparam logic [2:0] PH_RESET     = 3'd3;
  localparam logic [2:0] PH_SEEK      = 3'd4;
  localparam logic [2:0] PH_DONE      = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_DEBOUNCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_HIGH_TO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LOW_TO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_TICKS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEEK_TICKS    = 3'd5;

  // register reset values
  localparam logic [7:0]  RST_HIGH_DEBOUNCE = 8'd3;
  localparam logic [15:0] RST_WAIT_HIGH_TO  = 16'd500;
  localparam logic [15:0] RST_WAIT_LOW_TO   = 16'd500;
  localparam logic [15:0] RST_GAP_TICKS     = 16'd15;
  localparam logic [15:0] RST_RESET_TICKS   = 16'd20;
  localparam logic [15:0] RST_SEEK_TICKS    = 16'd10;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;
  localparam logic [7:0]  RUN_MAX  = 8'hFF;

  typedef struct packed {
    logic [7:0]  high_debounce_count;
    logic [15:0] wait_high_timeout;
    logic [15:0] wait_low_timeout;
    logic [15:0] gap_ticks;
    logic [15:0] reset_pulse_ticks;
    logic [15:0] seek_pulse_ticks;
  } bps_cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] tick_count;
    logic [7:0]  high_run;
  } bps_state_t;

  typedef struct packed {
    logic       reset_pulse;
    logic       seek_pulse;
    logic [2:0] phase_code;
  } bps_result_t;

endpackage

// ===== src/bps_if.sv =====
// Channel interfaces: tick input, result output and configuration write.
`timescale 1ns / 1ps

interface bps_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

interface bps_out_if;
  logic       valid;
  logic       ready;
  logic       reset_pulse;
  logic       seek_pulse;
  logic [2:0] phase_code;

  modport source (output valid, output reset_pulse, output seek_pulse,
                  output phase_code, input ready);
  modport sink   (input valid, input reset_pulse, input seek_pulse,
                  input phase_code, output ready);
endinterface

interface bps_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bps_pkg::CFG_IDX_W-1:0]  index;
  logic [bps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/boot_pulse_sequencer_unit.sv =====
// Top level of the boot pulse sequencer.
`timescale 1ns / 1ps

// Boot pulse sequencer. Each input word is one timer tick carrying the
// sampled pin level; each accepted tick yields exactly one result word with
// the reset and seek pulse levels for that tick and the phase after the
// step (0 wait high, 1 wait low, 2 gap, 3 reset, 4 seek, 5 done; done is
// terminal, and an illegal phase code falls into done). Throughput is one
// tick per clock while in_ch.ready is high: the phase, the 16-bit saturating
// tick counter and the 8-bit saturating high-run counter are updated in the
// cycle a tick is accepted, by saturating increments and compares. The result
// is registered before it reaches the output. A result register backed by a
// one-word skid stage decouples the two sides, so in_ch.ready drops only
// when two results are waiting. Configuration words are taken every cycle
// (cfg_ch.ready is tied high) and are meant to be written while the block
// is idle; indexes past the last register are ignored.
module boot_pulse_sequencer_unit (
  input  logic             clk,
  input  logic             rst_n,
  bps_in_if.sink           in_ch,
  bps_out_if.source        out_ch,
  bps_cfg_if.sink          cfg_ch
);

  bps_pkg::bps_cfg_t    cfg_r;
  bps_pkg::bps_state_t  state_r;
  bps_pkg::bps_state_t  state_nxt;
  bps_pkg::bps_result_t step_res;
  bps_pkg::bps_result_t out_res;
  logic                 in_ready;
  logic                 in_acc;
  logic                 out_valid;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;
  assign in_acc       = in_ch.valid & in_ready;

  // configuration registers; narrow registers take the low data bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_debounce_count <= bps_pkg::RST_HIGH_DEBOUNCE;
      cfg_r.wait_high_timeout   <= bps_pkg::RST_WAIT_HIGH_TO;
      cfg_r.wait_low_timeout    <= bps_pkg::RST_WAIT_LOW_TO;
      cfg_r.gap_ticks           <= bps_pkg::RST_GAP_TICKS;
      cfg_r.reset_pulse_ticks   <= bps_pkg::RST_RESET_TICKS;
      cfg_r.seek_pulse_ticks    <= bps_pkg::RST_SEEK_TICKS;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        bps_pkg::CFG_HIGH_DEBOUNCE: cfg_r.high_debounce_count <= cfg_ch.data[7:0];
        bps_pkg::CFG_WAIT_HIGH_TO:  cfg_r.wait_high_timeout   <= cfg_ch.data;
        bps_pkg::CFG_WAIT_LOW_TO:   cfg_r.wait_low_timeout    <= cfg_ch.data;
        bps_pkg::CFG_GAP_TICKS:     cfg_r.gap_ticks           <= cfg_ch.data;
        bps_pkg::CFG_RESET_TICKS:   cfg_r.reset_pulse_ticks   <= cfg_ch.data;
        bps_pkg::CFG_SEEK_TICKS:    cfg_r.seek_pulse_ticks    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // sequence step for the tick on the input
  bps_step u_step (
    .cfg       (cfg_r),
    .cur       (state_r),
    .pin_level (in_ch.pin_level),
    .nxt       (state_nxt),
    .res       (step_res)
  );

  // sequencer state advances only on an accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase      <= bps_pkg::PH_WAIT_HIGH;
      state_r.tick_count <= '0;
      state_r.high_run   <= '0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  bps_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_acc),
    .push_data  (step_res),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_res)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.reset_pulse = out_res.reset_pulse;
  assign out_ch.seek_pulse  = out_res.seek_pulse;
  assign out_ch.phase_code  = out_res.phase_code;

endmodule

// ===== src/bps_step.sv =====
// Next-state and per-tick result logic of the boot sequence.
`timescale 1ns / 1ps

module bps_step (
  input  bps_pkg::bps_cfg_t    cfg,
  input  bps_pkg::bps_state_t  cur,
  input  logic                 pin_level,
  output bps_pkg::bps_state_t  nxt,
  output bps_pkg::bps_result_t res
);

  logic [15:0] tick_inc;
  logic [7:0]  run_inc;

  // saturating increments
  assign tick_inc = (cur.tick_count == bps_pkg::TICK_MAX) ? cur.tick_count
                                                          : cur.tick_count + 16'd1;
  assign run_inc  = (cur.high_run == bps_pkg::RUN_MAX) ? cur.high_run
                                                       : cur.high_run + 8'd1;

  always_comb begin
    nxt             = cur;
    res.reset_pulse = 1'b0;
    res.seek_pulse  = 1'b0;
    case (cur.phase)
      bps_pkg::PH_WAIT_HIGH: begin
        if (pin_level) begin
          nxt.high_run = run_inc;
          if (run_inc >= cfg.high_debounce_count) begin
            nxt.phase      = bps_pkg::PH_WAIT_LOW;
            nxt.tick_count = '0;
            nxt.high_run   = '0;
          end
        end else begin
          // low ticks feed the timeout; high runs never clear it
          nxt.high_run   = '0;
          nxt.tick_count = tick_inc;
          if (tick_inc >= cfg.wait_high_timeout) begin
            nxt.phase      = bps_pkg::PH_WAIT_LOW;
            nxt.tick_count = '0;
          end
        end
      end
      bps_pkg::PH_WAIT_LOW: begin
        if (!pin_level || tick_inc >= cfg.wait_low_timeout) begin
          nxt.phase      = bps_pkg::PH_GAP;
          nxt.tick_count = '0;
        end else begin
          nxt.tick_count = tick_inc;
        end
      end
      bps_pkg::PH_GAP: begin
        if (tick_inc >= cfg.gap_ticks) begin
          nxt.phase       = bps_pkg::PH_RESET;
          nxt.tick_count  = '0;
          res.reset_pulse = 1'b1;
        end else begin
          nxt.tick_count = tick_inc;
        end
      end
      bps_pkg::PH_RESET: begin
        if (tick_inc >= cfg.reset_pulse_ticks) begin
          nxt.phase      = bps_pkg::PH_SEEK;
          nxt.tick_count = '0;
          res.seek_pulse = 1'b1;
        end else begin
          nxt.tick_count  = tick_inc;
          res.reset_pulse = 1'b1;
        end
      end
      bps_pkg::PH_SEEK: begin
        if (tick_inc >= cfg.seek_pulse_ticks) begin
          nxt.phase      = bps_pkg::PH_DONE;
          nxt.tick_count = '0;
        end else begin
          nxt.tick_count = tick_inc;
          res.seek_pulse = 1'b1;
        end
      end
      bps_pkg::PH_DONE: begin
        nxt = cur;
      end
      default: begin
        // illegal code: park in done, counters untouched
        nxt.phase = bps_pkg::PH_DONE;
      end
    endcase
    res.phase_code = nxt.phase;
  end

endmodule

// ===== src/bps_out_buf.sv =====
// Result register with a one-word skid stage; keeps in_ready registered.
`timescale 1ns / 1ps

module bps_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  bps_pkg::bps_result_t push_data,
  output logic                 push_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bps_pkg::bps_result_t out_data
);

  logic                 out_valid_r;
  logic                 skid_valid_r;
  bps_pkg::bps_result_t out_data_r;
  bps_pkg::bps_result_t skid_data_r;
  logic                 pop;

  assign pop        = out_valid_r & out_ready;
  assign push_ready = ~skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop && skid_valid_r) begin
      out_data_r   <= skid_data_r;
      skid_valid_r <= 1'b0;
    end else if (push && (!out_valid_r || pop)) begin
      out_data_r  <= push_data;
      out_valid_r <= 1'b1;
    end else if (push) begin
      skid_data_r  <= push_data;
      skid_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ===== src/bps_checker.sv =====
// Port-level assertions for the boot pulse sequencer, bound to the top level.
`timescale 1ns / 1ps

module bps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       reset_pulse,
  input logic       seek_pulse,
  input logic [2:0] phase_code
);

  logic done_seen_r;

  // done is terminal: remember once a done word has left
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_seen_r <= 1'b0;
    end else if (out_valid && out_ready && phase_code == bps_pkg::PH_DONE) begin
      done_seen_r <= 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(reset_pulse)
      && $stable(seek_pulse) && $stable(phase_code))
    else $error("stalled result word changed");

  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(reset_pulse && seek_pulse))
    else $error("reset and seek pulses both high");

  a_done_terminal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_seen_r |-> phase_code == bps_pkg::PH_DONE)
    else $error("phase left done");

endmodule

bind boot_pulse_sequencer_unit bps_checker u_bps_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .reset_pulse (out_ch.reset_pulse),
  .seek_pulse  (out_ch.seek_pulse),
  .phase_code  (out_ch.phase_code)
);
